>>> hw/rtl/spi_pkg.sv
// Package for the SPI master shift engine.
// Holds field widths, stream packing widths and configuration register indexes.
// No dependencies.
`default_nettype none

package spi_pkg;

    localparam int unsigned TxWidth     = 8;
    localparam int unsigned RxWidth     = 8;
    localparam int unsigned HalfWidth   = 16;
    localparam int unsigned BitCntWidth = 4;
    localparam int unsigned BitsPerByte = 8;

    localparam int unsigned InDataWidth  = 16;
    localparam int unsigned OutDataWidth = 16;

    localparam int unsigned CfgAddrWidth = 2;
    localparam int unsigned CfgDataWidth = 16;

    typedef enum logic [CfgAddrWidth-1:0] {
        CFG_CLOCK_POLARITY = 2'd0,
        CFG_LATE_PHASE     = 2'd1,
        CFG_HALF_PERIOD    = 2'd2,
        CFG_SELECT_ENABLE  = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

>>> hw/rtl/spi_master_shift_engine.sv
// SPI master shift engine: one input transaction per tick, one result per tick.
// Each result is registered; throughput: 1 transaction per cycle while m_tready
// is high, the output register drains while the next transaction is taken.
// Synchronous active-low reset: idle, select high, SCK at idle level,
// configuration at polarity 0, early phase, half period 0, select enabled.
// Depends on spi_pkg.
`default_nettype none

module spi_master_shift_engine (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [spi_pkg::CfgAddrWidth-1:0]     cfg_addr,
    input  wire logic [spi_pkg::CfgDataWidth-1:0]     cfg_wdata,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // s_tdata from bit 0: start_req, tx_byte[7:0], drive_mosi, release_select, miso
    input  wire logic [spi_pkg::InDataWidth-1:0]      s_tdata,
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // m_tdata from bit 0: sck, mosi, select_n, rx_byte[7:0], rx_valid, busy_res
    output logic [spi_pkg::OutDataWidth-1:0]          m_tdata
);
    import spi_pkg::*;

    // configuration
    logic                 clock_polarity_reg;
    logic                 late_phase_reg;
    logic [HalfWidth-1:0] half_period_reg;
    logic                 select_enable_reg;

    // engine state
    logic [HalfWidth-1:0]   tick_count_reg,  tick_count_next;
    logic [BitCntWidth-1:0] bit_count_reg,   bit_count_next;
    logic                   second_half_reg, second_half_next;
    logic [TxWidth-1:0]     out_shift_reg,   out_shift_next;
    logic [RxWidth-1:0]     in_shift_reg,    in_shift_next;
    logic                   active_reg,      active_next;
    logic                   sck_reg,         sck_next;
    logic                   mosi_reg,        mosi_next;
    logic                   select_reg,      select_next;
    logic                   release_reg,     release_next;
    logic                   drive_reg,       drive_next;
    logic                   rx_valid_next;

    logic                    m_tvalid_reg;
    logic [OutDataWidth-1:0] m_tdata_reg, m_tdata_next;

    logic               in_start;
    logic [TxWidth-1:0] in_tx;
    logic               in_drive;
    logic               in_release;
    logic               in_miso;
    logic               s_accept;

    assign in_start   = s_tdata[0];
    assign in_tx      = s_tdata[TxWidth:1];
    assign in_drive   = s_tdata[TxWidth+1];
    assign in_release = s_tdata[TxWidth+2];
    assign in_miso    = s_tdata[TxWidth+3];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_polarity_reg <= 1'b0;
            late_phase_reg     <= 1'b0;
            half_period_reg    <= '0;
            select_enable_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_CLOCK_POLARITY: clock_polarity_reg <= cfg_wdata[0];
                CFG_LATE_PHASE:     late_phase_reg     <= cfg_wdata[0];
                CFG_HALF_PERIOD:    half_period_reg    <= cfg_wdata[HalfWidth-1:0];
                CFG_SELECT_ENABLE:  select_enable_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        tick_count_next  = tick_count_reg;
        bit_count_next   = bit_count_reg;
        second_half_next = second_half_reg;
        out_shift_next   = out_shift_reg;
        in_shift_next    = in_shift_reg;
        active_next      = active_reg;
        sck_next         = sck_reg;
        mosi_next        = mosi_reg;
        select_next      = select_reg;
        release_next     = release_reg;
        drive_next       = drive_reg;
        rx_valid_next    = 1'b0;

        if (!active_reg) begin
            if (in_start) begin
                out_shift_next = in_tx;
                in_shift_next  = '0;
                drive_next     = in_drive;
                release_next   = in_release;
                if (select_enable_reg) begin
                    select_next = 1'b0;
                end
                bit_count_next = '0;
                active_next    = 1'b1;
                // leading edge of the first bit
                if (!late_phase_reg) begin
                    if (in_drive) begin
                        mosi_next = in_tx[TxWidth-1];
                    end
                    in_shift_next = {in_shift_next[RxWidth-2:0], in_miso};
                end
                sck_next         = 1'b1;
                second_half_next = 1'b0;
                tick_count_next  = '0;
            end
        end else if (tick_count_reg < half_period_reg) begin
            tick_count_next = tick_count_reg + HalfWidth'(1);
        end else begin
            tick_count_next = '0;
            if (!second_half_reg) begin
                // trailing edge
                if (late_phase_reg) begin
                    if (drive_reg) begin
                        mosi_next = out_shift_reg[TxWidth-1];
                    end
                    in_shift_next = {in_shift_reg[RxWidth-2:0], in_miso};
                end
                sck_next         = 1'b0;
                second_half_next = 1'b1;
            end else begin
                bit_count_next = bit_count_reg + BitCntWidth'(1);
                out_shift_next = {out_shift_reg[TxWidth-2:0], 1'b0};
                if (bit_count_next >= BitCntWidth'(BitsPerByte)) begin
                    rx_valid_next    = 1'b1;
                    active_next      = 1'b0;
                    second_half_next = 1'b0;
                    bit_count_next   = '0;
                    if (release_reg) begin
                        select_next = 1'b1;
                    end
                end else begin
                    // leading edge of the next bit
                    if (!late_phase_reg) begin
                        if (drive_reg) begin
                            mosi_next = out_shift_next[TxWidth-1];
                        end
                        in_shift_next = {in_shift_reg[RxWidth-2:0], in_miso};
                    end
                    sck_next         = 1'b1;
                    second_half_next = 1'b0;
                end
            end
        end
    end

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[0]                 = sck_next ^ clock_polarity_reg;
        m_tdata_next[1]                 = mosi_next;
        m_tdata_next[2]                 = select_next;
        m_tdata_next[RxWidth+2:3]       = in_shift_next;
        m_tdata_next[RxWidth+3]         = rx_valid_next;
        m_tdata_next[RxWidth+4]         = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            bit_count_reg   <= '0;
            second_half_reg <= 1'b0;
            out_shift_reg   <= '0;
            in_shift_reg    <= '0;
            active_reg      <= 1'b0;
            sck_reg         <= 1'b0;
            mosi_reg        <= 1'b0;
            select_reg      <= 1'b1;
            release_reg     <= 1'b0;
            drive_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                tick_count_reg  <= tick_count_next;
                bit_count_reg   <= bit_count_next;
                second_half_reg <= second_half_next;
                out_shift_reg   <= out_shift_next;
                in_shift_reg    <= in_shift_next;
                active_reg      <= active_next;
                sck_reg         <= sck_next;
                mosi_reg        <= mosi_next;
                select_reg      <= select_next;
                release_reg     <= release_next;
                drive_reg       <= drive_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the next transaction is accepted
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef ASSERT_OFF
    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= BitCntWidth'(BitsPerByte))
        else $error("bit counter beyond one byte");

    a_idle_counters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (tick_count_reg == '0) && (bit_count_reg == '0) && !second_half_reg)
        else $error("counters not cleared while idle");

    a_idle_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !active_reg && !in_start |=> !active_reg && $stable(select_reg))
        else $error("engine left idle without a start request");

    a_done_flag_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && rx_valid_next |=> !active_reg && !sck_reg && m_tvalid_reg)
        else $error("byte completion left engine active");
`endif

endmodule

`default_nettype wire
